// File: hdl/acio_pkg.sv
// ----------------------------------------------------------------------------
// acio_pkg
// Shared types and constants for the audio CPU I/O page: opcodes, I/O
// register map, timer control and status words.
// ----------------------------------------------------------------------------
package acio_pkg;

  // Default prescale periods in ticks
  localparam int SLOW_PRESCALE_DEF = 128;
  localparam int FAST_PRESCALE_DEF = 16;

  localparam int NUM_TIMERS = 3;
  localparam int NUM_PORTS  = 4;
  localparam int NUM_AUX    = 2;

  // Operation codes carried by each input word
  typedef enum logic [2:0] {
    OP_IO_READ    = 3'd0,
    OP_IO_WRITE   = 3'd1,
    OP_HOST_WRITE = 3'd2,
    OP_HOST_READ  = 3'd3,
    OP_TICK       = 3'd4
  } opcode_t;

  // I/O register map, low nibble of F0-FF
  localparam logic [3:0] IO_CONTROL = 4'h1;
  localparam logic [3:0] IO_PORT_LO = 4'h4;
  localparam logic [3:0] IO_PORT_HI = 4'h7;
  localparam logic [3:0] IO_AUX_LO  = 4'h8;
  localparam logic [3:0] IO_AUX_HI  = 4'h9;
  localparam logic [3:0] IO_DIV_LO  = 4'hA;
  localparam logic [3:0] IO_OUT_LO  = 4'hD;

  // Control register bit that selects the boot ROM overlay
  localparam int CTRL_OVERLAY_BIT = 7;

  // Divider value forced when a timer is switched off
  localparam logic [7:0] DIV_OFF_VALUE = 8'd1;

  // Per-timer control word, one update at most per word processed
  typedef struct packed {
    logic       step;       // prescaler strobe for this timer
    logic       ctrl_wr;    // control register write
    logic       enable;     // enable bit from the control write
    logic       div_wr;     // divider register write
    logic [7:0] div_data;
    logic       out_clear;  // output count read, clear it
  } timer_ctrl_t;

  // Per-timer status seen by the read mux
  typedef struct packed {
    logic [7:0] divider;
    logic [3:0] count;
  } timer_stat_t;

endpackage

// File: hdl/acio_prescaler.sv
// ----------------------------------------------------------------------------
// acio_prescaler
// Tick prescaler. Gives a slow strobe once per SLOW_PRESCALE ticks and a
// fast strobe once per FAST_PRESCALE ticks, the fast phase restarting with
// each slow period.
// ----------------------------------------------------------------------------
module acio_prescaler #(
  parameter int SLOW_PRESCALE = acio_pkg::SLOW_PRESCALE_DEF,
  parameter int FAST_PRESCALE = acio_pkg::FAST_PRESCALE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic tick,
  output logic slow_step,
  output logic fast_step
);
  import acio_pkg::*;

  localparam int SLOW_W = $clog2(SLOW_PRESCALE);
  localparam int FAST_W = $clog2(FAST_PRESCALE);

  logic [SLOW_W-1:0] slow_cnt;
  logic [FAST_W-1:0] fast_cnt;
  logic              slow_wrap;
  logic              fast_wrap;

  // Strobes look at the count before this tick advances it
  assign slow_step = (slow_cnt == '0);
  assign fast_step = (fast_cnt == '0);
  assign slow_wrap = (slow_cnt == SLOW_W'(SLOW_PRESCALE - 1));
  assign fast_wrap = (fast_cnt == FAST_W'(FAST_PRESCALE - 1));

  // Advance both counts on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_cnt <= '0;
      fast_cnt <= '0;
    end else if (tick) begin
      slow_cnt <= slow_wrap ? '0 : slow_cnt + 1'b1;
      fast_cnt <= (slow_wrap || fast_wrap) ? '0 : fast_cnt + 1'b1;
    end
  end

endmodule

// File: hdl/acio_timer.sv
// ----------------------------------------------------------------------------
// acio_timer
// One timer: enable, 8-bit divider (0 means 256), 8-bit stage counter and
// 4-bit output count that clears on read.
// ----------------------------------------------------------------------------
module acio_timer (
  input  logic                  clk,
  input  logic                  rst,
  input  acio_pkg::timer_ctrl_t ctl,
  output acio_pkg::timer_stat_t stat
);
  import acio_pkg::*;

  logic       enable;
  logic [7:0] divider;
  logic [7:0] stage;
  logic [3:0] count;
  logic [7:0] stage_plus;

  // Stage wraps at 256, so a zero divider matches after 256 steps
  assign stage_plus   = stage + 8'd1;
  assign stat.divider = divider;
  assign stat.count   = count;

  // Apply the single update carried by this word
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      divider <= '0;
      stage   <= '0;
      count   <= '0;
    end else if (ctl.ctrl_wr) begin
      enable <= ctl.enable;
      if (!ctl.enable) begin
        count   <= '0;
        divider <= DIV_OFF_VALUE;
      end
    end else if (ctl.div_wr) begin
      divider <= ctl.div_data;
    end else if (ctl.out_clear) begin
      count <= '0;
    end else if (ctl.step && enable) begin
      if (stage_plus == divider) begin
        stage <= '0;
        count <= count + 4'd1;
      end else begin
        stage <= stage_plus;
      end
    end
  end

endmodule

// File: hdl/audio_cpu_io_timers_mailbox.sv
// ----------------------------------------------------------------------------
// audio_cpu_io_timers_mailbox
// I/O page of an audio coprocessor: sixteen I/O registers, four mailbox
// ports in each direction, two auxiliary bytes, ROM overlay bit and three
// timers driven by tick words.
//
//   channel  handshake              payload
//   -------  ---------------------  --------------------------------------
//   in       in_valid / in_ready    opcode, io_index, host_port, write_data
//   out      out_valid / out_ready  read_data, rom_overlay
//
// One word per cycle sustained while the output is not stalled. A word
// is captured in the input register, decoded and applied to the state,
// and its result lands in the output register. A stalled output holds
// its word while the input register still takes one more.
// Reset clears all state, the overlay bit comes up set.
// ----------------------------------------------------------------------------
module audio_cpu_io_timers_mailbox #(
  parameter int SLOW_PRESCALE = acio_pkg::SLOW_PRESCALE_DEF,
  parameter int FAST_PRESCALE = acio_pkg::FAST_PRESCALE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [3:0] io_index,
  input  logic [1:0] host_port,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       rom_overlay
);
  import acio_pkg::*;

  // Input register
  logic       in_valid_q;
  logic [2:0] op_q;
  logic [3:0] idx_q;
  logic [1:0] port_q;
  logic [7:0] data_q;
  logic       advance;

  // State
  logic [7:0] h2c_ports [NUM_PORTS];
  logic [7:0] c2h_ports [NUM_PORTS];
  logic [7:0] aux_bytes [NUM_AUX];
  logic       overlay;

  // Decode
  opcode_t     op;
  logic [7:0]  rd;
  logic        h2c_we;
  logic        c2h_we;
  logic        aux_we;
  logic        overlay_we;
  logic        overlay_next;
  logic        tick;
  logic        slow_step;
  logic        fast_step;
  timer_ctrl_t tctl [NUM_TIMERS];
  timer_stat_t tstat [NUM_TIMERS];

  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;
  assign op       = opcode_t'(op_q);

  // Capture an input word whenever the register is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      idx_q  <= io_index;
      port_q <= host_port;
      data_q <= write_data;
    end
  end

  // Decode the held word into a read value and update strobes
  always_comb begin
    rd         = '0;
    h2c_we     = 1'b0;
    c2h_we     = 1'b0;
    aux_we     = 1'b0;
    overlay_we = 1'b0;
    tick       = 1'b0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tctl[t].step      = 1'b0;
      tctl[t].ctrl_wr   = 1'b0;
      tctl[t].enable    = data_q[t];
      tctl[t].div_wr    = 1'b0;
      tctl[t].div_data  = data_q;
      tctl[t].out_clear = 1'b0;
    end
    case (op)
      OP_IO_READ: begin
        if (idx_q inside {[IO_PORT_LO:IO_PORT_HI]}) begin
          rd = h2c_ports[idx_q[1:0]];
        end else if (idx_q inside {[IO_AUX_LO:IO_AUX_HI]}) begin
          rd = aux_bytes[idx_q[0]];
        end
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (idx_q == IO_DIV_LO + 4'(t)) begin
            rd = tstat[t].divider;
          end
          if (idx_q == IO_OUT_LO + 4'(t)) begin
            rd                = {4'b0, tstat[t].count};
            tctl[t].out_clear = advance;
          end
        end
      end
      OP_IO_WRITE: begin
        if (idx_q == IO_CONTROL) begin
          overlay_we = advance;
          for (int t = 0; t < NUM_TIMERS; t++) begin
            tctl[t].ctrl_wr = advance;
          end
        end else if (idx_q inside {[IO_PORT_LO:IO_PORT_HI]}) begin
          c2h_we = advance;
        end else if (idx_q inside {[IO_AUX_LO:IO_AUX_HI]}) begin
          aux_we = advance;
        end
        for (int t = 0; t < NUM_TIMERS; t++) begin
          if (idx_q == IO_DIV_LO + 4'(t)) begin
            tctl[t].div_wr = advance;
          end
        end
      end
      OP_HOST_WRITE: h2c_we = advance;
      OP_HOST_READ:  rd = c2h_ports[port_q];
      OP_TICK:       tick = advance;
      default:       rd = '0;
    endcase
    // Slow strobe feeds timers 0 and 1, fast strobe the last timer
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tctl[t].step = tick && ((t == NUM_TIMERS - 1) ? fast_step : slow_step);
    end
  end

  assign overlay_next = overlay_we ? data_q[CTRL_OVERLAY_BIT] : overlay;

  // Mailbox, auxiliary bytes and overlay bit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        h2c_ports[i] <= '0;
        c2h_ports[i] <= '0;
      end
      for (int i = 0; i < NUM_AUX; i++) begin
        aux_bytes[i] <= '0;
      end
      overlay <= 1'b1;
    end else begin
      if (h2c_we) begin
        h2c_ports[port_q] <= data_q;
      end
      if (c2h_we) begin
        c2h_ports[idx_q[1:0]] <= data_q;
      end
      if (aux_we) begin
        aux_bytes[idx_q[0]] <= data_q;
      end
      overlay <= overlay_next;
    end
  end

  acio_prescaler #(
    .SLOW_PRESCALE(SLOW_PRESCALE),
    .FAST_PRESCALE(FAST_PRESCALE)
  ) u_prescaler (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .slow_step(slow_step),
    .fast_step(fast_step)
  );

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
    acio_timer u_timer (
      .clk (clk),
      .rst (rst),
      .ctl (tctl[g]),
      .stat(tstat[g])
    );
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= rd;
      rom_overlay <= overlay_next;
    end
  end

`ifndef SYNTHESIS
  // A held word that cannot advance stays in the input register
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(op_q) && $stable(data_q))
    else $error("input word lost while stalled");

  // Every processed word produces a result
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed word without result");

  // Ready drops only with a full input register behind a stalled output
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_valid_q && out_valid && !out_ready)
    else $error("ready low without backpressure");

  // A control write shows its overlay bit in the same result
  a_overlay_write: assert property (@(posedge clk) disable iff (rst)
    advance && op_q == OP_IO_WRITE && idx_q == IO_CONTROL
    |=> rom_overlay == $past(data_q[CTRL_OVERLAY_BIT]))
    else $error("overlay bit mismatch after control write");
`endif

endmodule

// File: bench/audio_cpu_io_timers_mailbox_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_cpu_io_timers_mailbox_tb
// Drives bus reads, bus writes, host mailbox traffic and timer ticks into the
// I/O page. A model of the page inside the bench predicts each result word,
// and the output words are checked in order. It runs three idle patterns and
// one long output stall.
// ----------------------------------------------------------------------------
module audio_cpu_io_timers_mailbox_tb;
  import acio_pkg::*;

  // Opcodes past the defined set, and I/O indexes with no register behind them
  localparam logic [2:0] OP_SPARE_LO   = 3'd5;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam logic [3:0] IO_UNUSED_LO  = 4'h0;
  localparam logic [3:0] IO_UNUSED_MID = 4'h2;
  localparam logic [3:0] IO_UNUSED_HI  = 4'h3;

  localparam int PHASE_WORDS    = 160;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] idx;
    logic [1:0] port;
    logic [7:0] data;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       ovl;
  } page_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] opcode = '0;
  logic [3:0] io_index = '0;
  logic [1:0] host_port = '0;
  logic [7:0] write_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic       rom_overlay;

  audio_cpu_io_timers_mailbox dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .io_index    (io_index),
    .host_port   (host_port),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .rom_overlay (rom_overlay)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Page state as the bench sees it
  logic [7:0] mbox_from_host [NUM_PORTS];
  logic [7:0] mbox_to_host   [NUM_PORTS];
  logic [7:0] aux_reg        [NUM_AUX];
  logic       overlay_sel;
  logic       tmr_en    [NUM_TIMERS];
  logic [7:0] tmr_div   [NUM_TIMERS];
  logic [7:0] tmr_stage [NUM_TIMERS];
  logic [3:0] tmr_count [NUM_TIMERS];
  int         prescale_phase;

  bus_word_t    send_q[$];
  page_result_t page_results_q[$];

  int words_queued = 0;
  int words_taken = 0;
  int words_checked = 0;
  int ticks_seen = 0;
  int count_hits = 0;
  int failures = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  logic in_fire = 1'b0;

  function automatic void clear_page();
    for (int i = 0; i < NUM_PORTS; i++) begin
      mbox_from_host[i] = '0;
      mbox_to_host[i] = '0;
    end
    for (int i = 0; i < NUM_AUX; i++) aux_reg[i] = '0;
    overlay_sel = 1'b1;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_en[t] = 1'b0;
      tmr_div[t] = '0;
      tmr_stage[t] = '0;
      tmr_count[t] = '0;
    end
    prescale_phase = 0;
  endfunction

  // Advance one timer stage; a stage meeting the divider bumps the count
  function automatic void step_timer(int t);
    if (tmr_en[t]) begin
      tmr_stage[t] = tmr_stage[t] + 8'd1;
      if (tmr_stage[t] == tmr_div[t]) begin
        tmr_count[t] = tmr_count[t] + 4'd1;
        tmr_stage[t] = '0;
      end
    end
  endfunction

  // Apply one word to the page state and return the word it answers with
  function automatic page_result_t step_io_page(bus_word_t w);
    page_result_t r;
    int t;
    r.rd = '0;
    case (w.op)
      OP_IO_READ: begin
        if (w.idx >= IO_PORT_LO && w.idx <= IO_PORT_HI) begin
          r.rd = mbox_from_host[w.idx[1:0]];
        end else if (w.idx == IO_AUX_LO || w.idx == IO_AUX_HI) begin
          r.rd = aux_reg[w.idx[0]];
        end else if (w.idx >= IO_DIV_LO && w.idx < IO_OUT_LO) begin
          r.rd = tmr_div[2'(w.idx - IO_DIV_LO)];
        end else if (w.idx >= IO_OUT_LO) begin
          t = int'(w.idx - IO_OUT_LO);
          r.rd = {4'd0, tmr_count[t]};
          if (tmr_count[t] != 0) count_hits++;
          tmr_count[t] = '0;
        end
      end
      OP_IO_WRITE: begin
        if (w.idx == IO_CONTROL) begin
          for (t = 0; t < NUM_TIMERS; t++) begin
            if (w.data[t]) begin
              tmr_en[t] = 1'b1;
            end else begin
              tmr_en[t] = 1'b0;
              tmr_count[t] = '0;
              tmr_div[t] = DIV_OFF_VALUE;
            end
          end
          overlay_sel = w.data[CTRL_OVERLAY_BIT];
        end else if (w.idx >= IO_PORT_LO && w.idx <= IO_PORT_HI) begin
          mbox_to_host[w.idx[1:0]] = w.data;
        end else if (w.idx == IO_AUX_LO || w.idx == IO_AUX_HI) begin
          aux_reg[w.idx[0]] = w.data;
        end else if (w.idx >= IO_DIV_LO && w.idx < IO_OUT_LO) begin
          tmr_div[2'(w.idx - IO_DIV_LO)] = w.data;
        end
      end
      OP_HOST_WRITE: mbox_from_host[w.port] = w.data;
      OP_HOST_READ:  r.rd = mbox_to_host[w.port];
      OP_TICK: begin
        ticks_seen++;
        if (prescale_phase == 0) begin
          step_timer(0);
          step_timer(1);
        end
        if (prescale_phase % FAST_PRESCALE_DEF == 0) step_timer(2);
        prescale_phase = (prescale_phase + 1) % SLOW_PRESCALE_DEF;
      end
      default: ;
    endcase
    r.ovl = overlay_sel;
    return r;
  endfunction

  // Present the next pending word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        opcode     <= send_q[0].op;
        io_index   <= send_q[0].idx;
        host_port  <= send_q[0].port;
        write_data <= send_q[0].data;
        void'(send_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure, plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check results first, then predict the word taken at this edge
  always @(posedge clk) begin
    page_result_t want;
    bus_word_t    taken;
    if (rst) begin
      in_fire <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (page_results_q.size() == 0) begin
          $error("result word with nothing expected: read_data %0h rom_overlay %0b",
                 read_data, rom_overlay);
          failures++;
        end else begin
          want = page_results_q.pop_front();
          words_checked++;
          if (read_data !== want.rd) begin
            $error("read_data: expected %0h, got %0h", want.rd, read_data);
            failures++;
          end
          if (rom_overlay !== want.ovl) begin
            $error("rom_overlay: expected %0b, got %0b", want.ovl, rom_overlay);
            failures++;
          end
        end
      end
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken = {opcode, io_index, host_port, write_data};
        page_results_q.push_back(step_io_page(taken));
        words_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_word(input logic [2:0] op, input logic [3:0] idx,
                            input logic [1:0] port, input logic [7:0] data);
    bus_word_t w;
    w = {op, idx, port, data};
    send_q.push_back(w);
    words_queued++;
  endtask

  // One burst of traffic: mostly a timer program, tick run and readback,
  // sometimes plain noise over every field
  task automatic queue_episode();
    logic [7:0] d;
    logic [1:0] p;
    int t;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 4))
        queue_word(3'($urandom_range(OP_IO_READ, OP_SPARE_HI)),
                   4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(99) < 40) begin
      d = 8'($urandom_range(0, 255));
      for (t = 0; t < NUM_TIMERS; t++) d[t] = ($urandom_range(99) < 80);
      queue_word(OP_IO_WRITE, IO_CONTROL, 2'($urandom_range(0, 3)), d);
    end
    for (t = 0; t < NUM_TIMERS; t++) begin
      if ($urandom_range(99) < 30) begin
        d = ($urandom_range(99) < 75) ? 8'($urandom_range(1, 6))
                                      : 8'($urandom_range(0, 255));
        queue_word(OP_IO_WRITE, IO_DIV_LO + 4'(t), 2'($urandom_range(0, 3)), d);
      end
    end
    repeat ($urandom_range(4, 48))
      queue_word(OP_TICK, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
    if ($urandom_range(99) < 50) begin
      p = 2'($urandom_range(0, 3));
      queue_word(OP_HOST_WRITE, 4'($urandom_range(0, 15)), p,
                 8'($urandom_range(0, 255)));
      queue_word(OP_IO_READ, IO_PORT_LO + p, 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 50) begin
      p = 2'($urandom_range(0, 3));
      queue_word(OP_IO_WRITE, IO_PORT_LO + p, 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      queue_word(OP_HOST_READ, 4'($urandom_range(0, 15)), p,
                 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 25) begin
      p = 2'($urandom_range(0, 1));
      queue_word(OP_IO_WRITE, IO_AUX_LO + p, 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      queue_word(OP_IO_READ, IO_AUX_LO + p, 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 20)
      queue_word(OP_IO_READ, IO_DIV_LO + 4'($urandom_range(0, NUM_TIMERS - 1)),
                 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    if ($urandom_range(99) < 70) begin
      for (t = 0; t < NUM_TIMERS; t++)
        if ($urandom_range(99) < 60)
          queue_word(OP_IO_READ, IO_OUT_LO + 4'(t), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || page_results_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    clear_page();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset values, mailbox and aux extremes, control, one tick
    send_idle_pct = 28;
    recv_idle_pct = 54;
    queue_word(OP_IO_READ, IO_UNUSED_LO, 2'd0, 8'h00);
    queue_word(OP_IO_READ, IO_DIV_LO, 2'd3, 8'hFF);
    queue_word(OP_HOST_WRITE, IO_UNUSED_LO, 2'd0, 8'hFF);
    queue_word(OP_HOST_WRITE, IO_UNUSED_LO, 2'd3, 8'h80);
    queue_word(OP_IO_READ, IO_PORT_LO, 2'd0, 8'h00);
    queue_word(OP_IO_READ, IO_PORT_HI, 2'd0, 8'h00);
    queue_word(OP_IO_WRITE, IO_PORT_LO, 2'd0, 8'hFF);
    queue_word(OP_IO_WRITE, IO_PORT_HI, 2'd0, 8'h01);
    queue_word(OP_HOST_READ, IO_UNUSED_LO, 2'd0, 8'h00);
    queue_word(OP_HOST_READ, IO_UNUSED_LO, 2'd3, 8'h00);
    queue_word(OP_IO_WRITE, IO_AUX_LO, 2'd0, 8'hFF);
    queue_word(OP_IO_WRITE, IO_AUX_HI, 2'd0, 8'h7F);
    queue_word(OP_IO_READ, IO_AUX_LO, 2'd0, 8'h00);
    queue_word(OP_IO_READ, IO_AUX_HI, 2'd0, 8'h00);
    // Switch everything off: dividers go to one, overlay drops
    queue_word(OP_IO_WRITE, IO_CONTROL, 2'd0, 8'h00);
    queue_word(OP_IO_READ, IO_DIV_LO + 4'd1, 2'd0, 8'h00);
    queue_word(OP_IO_WRITE, IO_CONTROL, 2'd0, 8'h87);
    queue_word(OP_IO_WRITE, IO_DIV_LO + 4'd2, 2'd0, 8'h01);
    queue_word(OP_TICK, 4'hF, 2'd3, 8'hFF);
    queue_word(OP_IO_READ, IO_OUT_LO + 4'd2, 2'd0, 8'h00);
    queue_word(OP_IO_READ, IO_OUT_LO, 2'd0, 8'h00);
    // Second read of a count comes back cleared
    queue_word(OP_IO_READ, IO_OUT_LO, 2'd0, 8'h00);
    queue_word(OP_IO_WRITE, IO_OUT_LO, 2'd0, 8'hFF);
    queue_word(OP_IO_WRITE, IO_UNUSED_MID, 2'd0, 8'hFF);
    queue_word(OP_IO_WRITE, IO_UNUSED_HI, 2'd0, 8'h00);
    queue_word(OP_SPARE_LO, IO_PORT_LO, 2'd1, 8'hAA);
    queue_word(OP_SPARE_HI, IO_CONTROL, 2'd2, 8'h00);

    // Random traffic under three idle patterns
    target = words_queued + PHASE_WORDS;
    while (words_queued < target) queue_episode();
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 28;
    target = words_queued + PHASE_WORDS;
    while (words_queued < target) queue_episode();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = words_queued + PHASE_WORDS;
    while (words_queued < target) queue_episode();
    // Stall the output long enough to back the page up into its input
    hold_req = hold_req + 1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d ticks) and checked %0d results;", words_taken,
             ticks_seen, words_checked);
    $display("%0d timer count reads saw a nonzero count.", count_hits);
    if (failures == 0 && page_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/acio_pkg.sv
hdl/acio_prescaler.sv
hdl/acio_timer.sv
hdl/audio_cpu_io_timers_mailbox.sv
bench/audio_cpu_io_timers_mailbox_tb.sv
